### rtl/core/pss_pkg.sv
// pss_pkg: shared constants and types of the polynomial sse accumulator
// used by pss_cell, pss_mul and polynomial_sse_accumulator
package pss_pkg;

    localparam int MAX_COEFFS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 48;
    localparam int SUM_W      = 63;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST   = 3'd6;

    localparam logic signed [ACC_W-1:0] SAT48_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT48_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]        SUM_MAX   = {SUM_W{1'b1}};

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

### rtl/core/pss_cell.sv
// pss_cell: one coefficient cell of the shifting coefficient chain
// depends on pss_pkg
module pss_cell (
    input  logic                             i_clk,
    input  pss_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [pss_pkg::DATA_W-1:0] i_load_val,
    input  logic signed [pss_pkg::DATA_W-1:0] i_prev,
    output logic signed [pss_pkg::DATA_W-1:0] o_coef
);

    logic signed [pss_pkg::DATA_W-1:0] r_coef;
    logic signed [pss_pkg::DATA_W-1:0] n_coef;

    always_comb begin
        n_coef = r_coef;
        if (i_ctrl.load) begin
            n_coef = i_load_val;
        end else if (i_ctrl.shift) begin
            n_coef = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

### rtl/core/pss_mul.sv
// pss_mul: registered 32x32 unsigned multiplier shared by horner and square
// depends on pss_pkg
module pss_mul (
    input  logic                        i_clk,
    input  logic [pss_pkg::DATA_W-1:0]  i_a,
    input  logic [pss_pkg::DATA_W-1:0]  i_b,
    output logic [pss_pkg::PROD_W-1:0]  o_p
);

    logic [pss_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {{pss_pkg::DATA_W{1'b0}}, i_a} * {{pss_pkg::DATA_W{1'b0}}, i_b};
    end

    assign o_p = r_p;

endmodule

### rtl/core/polynomial_sse_accumulator.sv
// polynomial_sse_accumulator: top level, sequencer, config registers and datapath
// depends on pss_pkg, pss_cell, pss_mul
//
// usage: samples (x, y, last) enter on the in channel with valid and ready; one
// request is taken whenever the block is idle. each x runs through the polynomial
// of coeff_count coefficients (capped at six) by horner's rule, the residual is
// squared and added to the saturating sum. the result channel carries the sum and
// the sticky saturation flag only for a sample marked last; sum and flag clear then.
// config writes go in on their own channel, always ready, index 0 is coeff_count
// and 1..6 are coef_0..coef_5; write only while the block is idle.
// sequence: the coefficient chain first shifts into place, one cell per cycle, then
// each horner step passes through the states mlo, mhi, comb and sumc on the one
// shared 32x32 multiplier, then come the square and the accumulate. a last sample
// then passes through the out state, which moves its result into the output
// register once that register is free; from the next cycle it is valid there.
// the next sample is taken while that result waits; a further last sample waits
// until it is taken.
// reset: coeff_count 2, coefficients 0, sum and flag clear, no result pending.
module polynomial_sse_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [pss_pkg::DATA_W-1:0]     i_x_sample,
    input  logic signed [pss_pkg::DATA_W-1:0]     i_y_sample,
    input  logic                                  i_last_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [pss_pkg::SUM_W-1:0]             o_error_sum,
    output logic                                  o_saturated,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pss_pkg::DATA_W-1:0]            i_cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ALIGN = 9'b000000010,
        ST_MLO   = 9'b000000100,
        ST_MHI   = 9'b000001000,
        ST_COMB  = 9'b000010000,
        ST_SUMC  = 9'b000100000,
        ST_SQ    = 9'b001000000,
        ST_ACC   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    localparam int PP_W = pss_pkg::ACC_W + pss_pkg::DATA_W;
    localparam int EX_W = pss_pkg::ACC_W + 2;

    t_state r_state, n_state;

    logic [pss_pkg::CNT_W-1:0]          r_count;
    logic signed [pss_pkg::DATA_W-1:0]  r_coef [pss_pkg::MAX_COEFFS];
    logic [pss_pkg::CNT_W-1:0]          w_n;

    logic [pss_pkg::DATA_W-1:0]         r_xabs;
    logic                               r_xneg;
    logic signed [pss_pkg::DATA_W-1:0]  r_y;
    logic                               r_last;

    logic [pss_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [pss_pkg::CNT_W-1:0]          r_steps, n_steps;
    logic signed [pss_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [pss_pkg::PROD_W-1:0]         r_pl, n_pl;
    logic signed [EX_W-1:0]             r_prod, n_prod;
    logic                               r_rbig, n_rbig;
    logic [pss_pkg::SUM_W-1:0]          r_err, n_err;
    logic                               r_sat, n_sat;

    logic                               r_out_valid, n_out_valid;
    logic [pss_pkg::SUM_W-1:0]          r_out_sum, n_out_sum;
    logic                               r_out_sat, n_out_sat;

    pss_pkg::t_cell_ctrl                w_ctrl;
    logic signed [pss_pkg::DATA_W-1:0]  w_cell [pss_pkg::MAX_COEFFS];
    logic signed [pss_pkg::DATA_W-1:0]  w_head;

    logic [pss_pkg::DATA_W-1:0]         w_mul_a, w_mul_b;
    logic [pss_pkg::PROD_W-1:0]         w_mul_p;

    logic [pss_pkg::ACC_W-1:0]          w_acc_abs;
    logic [PP_W-1:0]                    w_pp;
    logic [PP_W-1:0]                    w_mag_full;
    logic                               w_mag_sat;
    logic [pss_pkg::ACC_W:0]            w_mag;
    logic signed [EX_W-1:0]             w_csum;
    logic signed [EX_W-1:0]             w_res;
    logic [EX_W-1:0]                    w_res_abs;
    logic [pss_pkg::SUM_W-1:0]          w_sq;
    logic                               w_sq_sat;
    logic [pss_pkg::SUM_W:0]            w_sum;
    logic                               w_accept;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_n = (r_count > 3'(pss_pkg::MAX_COEFFS)) ? 3'(pss_pkg::MAX_COEFFS) : r_count;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd2;
            for (int i = 0; i < pss_pkg::MAX_COEFFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pss_pkg::CFG_COEFF_COUNT) begin
                r_count <= i_cfg_data[pss_pkg::CNT_W-1:0];
            end else if (i_cfg_index <= pss_pkg::CFG_COEF_LAST) begin
                r_coef[3'(i_cfg_index - 3'd1)] <= i_cfg_data;
            end
        end
    end

    // coefficient chain, highest cell is the head
    genvar g;
    generate
        for (g = 0; g < pss_pkg::MAX_COEFFS; g++) begin : g_cell
            if (g == 0) begin : g_first
                pss_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_load_val (r_coef[g]),
                    .i_prev     ({pss_pkg::DATA_W{1'b0}}),
                    .o_coef     (w_cell[g])
                );
            end else begin : g_rest
                pss_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctrl     (w_ctrl),
                    .i_load_val (r_coef[g]),
                    .i_prev     (w_cell[g-1]),
                    .o_coef     (w_cell[g])
                );
            end
        end
    endgenerate

    assign w_head = w_cell[pss_pkg::MAX_COEFFS-1];

    pss_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // datapath
    always_comb begin
        w_acc_abs  = r_acc[pss_pkg::ACC_W-1] ? pss_pkg::ACC_W'(-r_acc) : pss_pkg::ACC_W'(r_acc);
        w_pp       = PP_W'(r_pl) + {w_mul_p[pss_pkg::ACC_W-1:0], {pss_pkg::DATA_W{1'b0}}};
        w_mag_full = w_pp >> pss_pkg::FRAC_BITS;
        w_mag_sat  = (|w_mag_full[PP_W-1:pss_pkg::ACC_W+1])
                     || (w_mag_full[pss_pkg::ACC_W] && (|w_mag_full[pss_pkg::ACC_W-1:0]));
        w_mag      = w_mag_sat ? {1'b1, {pss_pkg::ACC_W{1'b0}}} : w_mag_full[pss_pkg::ACC_W:0];
        w_csum     = r_prod + EX_W'(w_head);
        w_res      = EX_W'(r_acc) - EX_W'(r_y);
        w_res_abs  = w_res[EX_W-1] ? EX_W'(-w_res) : EX_W'(w_res);
        w_sq_sat   = r_rbig || w_mul_p[pss_pkg::PROD_W-1];
        w_sq       = w_sq_sat ? pss_pkg::SUM_MAX : w_mul_p[pss_pkg::SUM_W-1:0];
        w_sum      = {1'b0, r_err} + {1'b0, w_sq};
    end

    // multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = r_xabs;
        unique case (r_state)
            ST_MLO: w_mul_a = w_acc_abs[pss_pkg::DATA_W-1:0];
            ST_MHI: w_mul_a = pss_pkg::DATA_W'(w_acc_abs[pss_pkg::ACC_W-1:pss_pkg::DATA_W]);
            ST_SQ: begin
                w_mul_a = w_res_abs[pss_pkg::DATA_W-1:0];
                w_mul_b = w_res_abs[pss_pkg::DATA_W-1:0];
            end
            default: w_mul_a = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_steps     = r_steps;
        n_acc       = r_acc;
        n_pl        = r_pl;
        n_prod      = r_prod;
        n_rbig      = r_rbig;
        n_err       = r_err;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sum   = r_out_sum;
        n_out_sat   = r_out_sat;
        w_ctrl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctrl.load = 1'b1;
                    n_cnt       = 3'(pss_pkg::MAX_COEFFS) - w_n;
                    n_state     = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                w_ctrl.shift = 1'b1;
                if (r_cnt == '0) begin
                    n_acc   = pss_pkg::ACC_W'(w_head);
                    n_steps = (w_n == '0) ? '0 : w_n - 3'd1;
                    n_state = (w_n > 3'd1) ? ST_MLO : ST_SQ;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            ST_MLO: n_state = ST_MHI;
            ST_MHI: begin
                n_pl    = w_mul_p;
                n_state = ST_COMB;
            end
            ST_COMB: begin
                if (w_mag_sat) begin
                    n_sat = 1'b1;
                end
                n_prod  = (r_acc[pss_pkg::ACC_W-1] ^ r_xneg) ? -EX_W'(w_mag) : EX_W'(w_mag);
                n_state = ST_SUMC;
            end
            ST_SUMC: begin
                w_ctrl.shift = 1'b1;
                if ((w_csum[EX_W-1:pss_pkg::ACC_W-1] != '0)
                        && (w_csum[EX_W-1:pss_pkg::ACC_W-1] != '1)) begin
                    n_sat = 1'b1;
                    n_acc = w_csum[EX_W-1] ? pss_pkg::SAT48_MIN : pss_pkg::SAT48_MAX;
                end else begin
                    n_acc = w_csum[pss_pkg::ACC_W-1:0];
                end
                n_steps = r_steps - 3'd1;
                n_state = (r_steps == 3'd1) ? ST_SQ : ST_MLO;
            end
            ST_SQ: begin
                n_rbig  = |w_res_abs[EX_W-1:pss_pkg::DATA_W];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (w_sq_sat || w_sum[pss_pkg::SUM_W]) begin
                    n_sat = 1'b1;
                end
                n_err   = w_sum[pss_pkg::SUM_W] ? pss_pkg::SUM_MAX : w_sum[pss_pkg::SUM_W-1:0];
                n_state = r_last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_err;
                    n_out_sat   = r_sat;
                    n_err       = '0;
                    n_sat       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_err       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xabs <= i_x_sample[pss_pkg::DATA_W-1] ? pss_pkg::DATA_W'(-i_x_sample)
                                                    : pss_pkg::DATA_W'(i_x_sample);
            r_xneg <= i_x_sample[pss_pkg::DATA_W-1];
            r_y    <= i_y_sample;
            r_last <= i_last_sample;
        end
        r_cnt     <= n_cnt;
        r_steps   <= n_steps;
        r_acc     <= n_acc;
        r_pl      <= n_pl;
        r_prod    <= n_prod;
        r_rbig    <= n_rbig;
        r_out_sum <= n_out_sum;
        r_out_sat <= n_out_sat;
    end

    assign o_out_valid = r_out_valid;
    assign o_error_sum = r_out_sum;
    assign o_saturated = r_out_sat;

endmodule

### tb/polynomial_sse_accumulator_tb.sv
// polynomial_sse_accumulator_tb: self-checking bench for the polynomial sse accumulator
// predicts each data set sum and saturation flag and checks every result in order
// depends on pss_pkg and polynomial_sse_accumulator
module polynomial_sse_accumulator_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 150;
    localparam logic [pss_pkg::CFG_IDX_W-1:0] CFG_COEF_0 = pss_pkg::CFG_COEFF_COUNT + 3'd1;
    localparam logic [pss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = pss_pkg::CFG_COEF_LAST + 3'd1;
    localparam logic [127:0] HORNER_MAG_MAX = 128'd1 << 48;

    typedef struct packed {
        logic [pss_pkg::SUM_W-1:0] sum;
        logic                      sat;
    } t_sse_result;

    logic                               i_clk;
    logic                               i_rst_n       = 1'b0;
    logic                               i_in_valid    = 1'b0;
    logic                               o_in_ready;
    logic signed [pss_pkg::DATA_W-1:0]  i_x_sample    = '0;
    logic signed [pss_pkg::DATA_W-1:0]  i_y_sample    = '0;
    logic                               i_last_sample = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready   = 1'b0;
    logic [pss_pkg::SUM_W-1:0]          o_error_sum;
    logic                               o_saturated;
    logic                               i_cfg_valid   = 1'b0;
    logic                               o_cfg_ready;
    logic [pss_pkg::CFG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [pss_pkg::DATA_W-1:0]         i_cfg_data    = '0;

    // mirror of the block state
    logic [pss_pkg::CNT_W-1:0]          coef_count = 3'd2;
    logic signed [pss_pkg::DATA_W-1:0]  coefs [pss_pkg::MAX_COEFFS] = '{default: '0};
    logic [pss_pkg::SUM_W-1:0]          sse_acc = '0;
    logic                               sse_sat = 1'b0;

    t_sse_result expected_sums [$];
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int rx_stall_pct   = 0;
    int rx_hold_cycles = 0;

    polynomial_sse_accumulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .i_last_sample (i_last_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_error_sum   (o_error_sum),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic predict_sse(input logic signed [pss_pkg::DATA_W-1:0] x,
                               input logic signed [pss_pkg::DATA_W-1:0] y,
                               input logic is_last);
        int           n;
        longint       horner;
        longint       step;
        longint       resid;
        logic [63:0]  acc_mag;
        logic [63:0]  x_mag;
        logic [63:0]  resid_mag;
        logic [127:0] prod_mag;
        logic [127:0] sq_full;
        logic [63:0]  sum_full;
        logic [pss_pkg::SUM_W-1:0] sq;
        n = (int'(coef_count) > pss_pkg::MAX_COEFFS) ? pss_pkg::MAX_COEFFS : int'(coef_count);
        horner = 0;
        if (n > 0) begin
            horner = longint'(coefs[n - 1]);
            for (int k = n - 2; k >= 0; k--) begin
                acc_mag  = (horner < 0) ? -horner : horner;
                x_mag    = (x < 0) ? -longint'(x) : longint'(x);
                prod_mag = acc_mag * x_mag;
                prod_mag = prod_mag >> pss_pkg::FRAC_BITS;
                if (prod_mag > HORNER_MAG_MAX) begin
                    prod_mag = HORNER_MAG_MAX;
                    sse_sat = 1'b1;
                end
                step = longint'(prod_mag[63:0]);
                if ((horner < 0) != (x < 0)) begin
                    step = -step;
                end
                step = step + longint'(coefs[k]);
                if (step > longint'(pss_pkg::SAT48_MAX)) begin
                    step = longint'(pss_pkg::SAT48_MAX);
                    sse_sat = 1'b1;
                end else if (step < longint'(pss_pkg::SAT48_MIN)) begin
                    step = longint'(pss_pkg::SAT48_MIN);
                    sse_sat = 1'b1;
                end
                horner = step;
            end
        end
        resid     = horner - longint'(y);
        resid_mag = (resid < 0) ? -resid : resid;
        sq_full   = resid_mag * resid_mag;
        if (sq_full > pss_pkg::SUM_MAX) begin
            sq = pss_pkg::SUM_MAX;
            sse_sat = 1'b1;
        end else begin
            sq = sq_full[pss_pkg::SUM_W-1:0];
        end
        sum_full = {1'b0, sse_acc} + {1'b0, sq};
        if (sum_full > pss_pkg::SUM_MAX) begin
            sum_full = {1'b0, pss_pkg::SUM_MAX};
            sse_sat = 1'b1;
        end
        sse_acc = sum_full[pss_pkg::SUM_W-1:0];
        if (is_last) begin
            expected_sums.push_back(t_sse_result'{sum: sse_acc, sat: sse_sat});
            sse_acc = '0;
            sse_sat = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_sse_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sum=%h sat=%b",
                                              o_error_sum, o_saturated));
                end else begin
                    want = expected_sums.pop_front();
                    if (o_error_sum !== want.sum) begin
                        report_mismatch($sformatf("error_sum got %h want %h",
                                                  o_error_sum, want.sum));
                    end
                    if (o_saturated !== want.sat) begin
                        report_mismatch($sformatf("saturated got %b want %b",
                                                  o_saturated, want.sat));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pss_pkg::CFG_COEFF_COUNT) begin
                    coef_count = i_cfg_data[pss_pkg::CNT_W-1:0];
                end else if (i_cfg_index <= pss_pkg::CFG_COEF_LAST) begin
                    coefs[i_cfg_index - CFG_COEF_0] = i_cfg_data;
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_sse(i_x_sample, i_y_sample, i_last_sample);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: long hold-off first, random stalls otherwise
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [pss_pkg::DATA_W-1:0] rand_q16();
        logic [pss_pkg::DATA_W-1:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4, 5: return {{14{raw[17]}}, raw[17:0]};
            6, 7: return {{8{raw[23]}}, raw[23:0]};
            default: return raw;
        endcase
    endfunction

    task automatic send_sample(input logic [pss_pkg::DATA_W-1:0] x,
                               input logic [pss_pkg::DATA_W-1:0] y,
                               input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_x_sample    = x;
        i_y_sample    = y;
        i_last_sample = is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [pss_pkg::CFG_IDX_W-1:0] reg_index,
                                input logic [pss_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = reg_index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_poly(input logic [pss_pkg::CNT_W-1:0] count,
                             input logic [pss_pkg::DATA_W-1:0] c [pss_pkg::MAX_COEFFS]);
        logic [pss_pkg::DATA_W-1:0] data;
        drain_results();
        data = $urandom;
        data[pss_pkg::CNT_W-1:0] = count;
        write_config(pss_pkg::CFG_COEFF_COUNT, data);
        for (int k = 0; k < pss_pkg::MAX_COEFFS; k++) begin
            write_config(CFG_COEF_0 + pss_pkg::CFG_IDX_W'(k), c[k]);
        end
    endtask

    task automatic test_reset_state();
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        drain_results();
    endtask

    task automatic test_directed_cases();
        // constant term only
        load_poly(3'd1, '{32'h0001_0000, 0, 0, 0, 0, 0});
        send_sample(32'h1234_5678, 32'h0000_0000, 1'b1);
        // zero count gives a zero prediction
        load_poly(3'd0, '{32'h0003_0000, 32'h0003_0000, 32'h0003_0000,
                          32'h0003_0000, 32'h0003_0000, 32'h0003_0000});
        send_sample(32'h0002_0000, 32'h0001_0000, 1'b1);
        // count above the maximum acts as six
        load_poly(3'd7, '{32'h0001_0000, 32'hffff_0000, 32'h0000_8000,
                          32'h0000_4000, 32'hffff_c000, 32'h0000_2000});
        send_sample(32'h0001_8000, 32'h0000_4000, 1'b0);
        send_sample(32'hfffe_8000, 32'h0000_0000, 1'b1);
        // horner saturation at both ends
        load_poly(3'd6, '{default: 32'h7fff_ffff});
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        load_poly(3'd6, '{default: 32'h8000_0000});
        send_sample(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        // square saturation
        load_poly(3'd3, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0});
        send_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // sum saturation, then the flag clears on the next set
        load_poly(3'd1, '{default: 32'h0000_0000});
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b1);
        send_sample(32'h0001_0000, 32'h0001_0000, 1'b1);
        // write past the last coefficient is ignored
        load_poly(3'd2, '{32'h0000_8000, 32'h0002_0000, 0, 0, 0, 0});
        write_config(CFG_UNUSED_INDEX, $urandom);
        send_sample(32'h0002_0000, 32'h0000_0001, 1'b0);
        send_sample(32'h0000_0000, 32'hffff_0000, 1'b1);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        load_poly(3'd4, '{32'h0000_4000, 32'hffff_8000, 32'h0001_0000,
                          32'h0000_2000, 0, 0});
        rx_hold_cycles = HOLD_CYCLES;
        for (int j = 0; j < 6; j++) begin
            send_sample(rand_q16(), rand_q16(), 1'b1);
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int num_items);
        int sent;
        int next_config;
        int len;
        logic [pss_pkg::CNT_W-1:0] count;
        logic [pss_pkg::DATA_W-1:0] c [pss_pkg::MAX_COEFFS];
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        sent = 0;
        next_config = 0;
        while (sent < num_items) begin
            if (sent >= next_config) begin
                case ($urandom_range(0, 9))
                    0: count = 3'd0;
                    1: count = 3'd7;
                    default: count = pss_pkg::CNT_W'($urandom_range(1, pss_pkg::MAX_COEFFS));
                endcase
                for (int k = 0; k < pss_pkg::MAX_COEFFS; k++) begin
                    c[k] = rand_q16();
                end
                load_poly(count, c);
                next_config = sent + 60;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int j = 1; j <= len; j++) begin
                send_sample(rand_q16(), rand_q16(), j == len);
            end
            sent += len;
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_directed_cases();
        test_output_backpressure();
        test_random_traffic(0, 0, 255);
        test_random_traffic(61, 0, 255);
        test_random_traffic(0, 61, 255);
        test_random_traffic(17, 17, 255);
        drain_results();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
